// ----- rtl/dbrv_pkg.sv -----
// Package for the depth-based right view warp block.
// Holds shared types, codes and constants; no dependencies.
package dbrv_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = 10;
  localparam int ADDR_W    = COL_W + 1;
  localparam int GEN_W     = 10;
  localparam int PIX_W     = 24;
  localparam int WORD_W    = 1 + GEN_W + PIX_W;
  localparam int DIV_W     = 25;
  localparam int DIV_CNT_W = 5;

  // register indexes on the configuration port
  localparam logic [1:0] REG_DEPTH_MAX = 2'd0;
  localparam logic [1:0] REG_NUMER     = 2'd1;
  localparam logic [1:0] REG_WIDTH     = 2'd2;

  localparam logic [15:0] DEPTH_MAX_RST = 16'd65535;
  localparam logic [23:0] NUMER_RST     = 24'd3162000;
  localparam logic [10:0] WIDTH_RST     = 11'd320;

  // gray weights, scaled by 1000, and the hole threshold
  localparam logic [17:0] LUMA_R    = 18'd299;
  localparam logic [17:0] LUMA_G    = 18'd587;
  localparam logic [17:0] LUMA_B    = 18'd114;
  localparam logic [17:0] LUMA_HOLE = 18'd500;

  typedef struct packed {
    logic [15:0] depth_max;
    logic [23:0] numer;
    logic [10:0] width;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MUL, ST_PROD, ST_DEC, ST_DIV,
    ST_WRITE, ST_SRD, ST_SWR, ST_DONE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    MEM_NONE, MEM_EMIT_RD, MEM_PLACE_WR, MEM_SCRUB_RD, MEM_SCRUB_WR, MEM_CLEAR_WR
  } mem_op_t;

  typedef struct packed {
    logic    load_in;
    logic    calc_cm;
    logic    calc_prod;
    logic    capture;
    logic    div_start;
    logic    finish;
    mem_op_t mem_op;
  } cmd_t;

  typedef struct packed {
    logic place_black;
    logic div_busy;
    logic ptr_last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/dbrv_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on dbrv_pkg.
module dbrv_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dbrv_pkg::DIV_W-1:0]    dividend,
  input  logic [23:0]                   divisor,
  output logic                          busy,
  output logic [dbrv_pkg::DIV_W-1:0]    quotient
);

  logic                              busy_r, busy_nxt;
  logic [dbrv_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [23:0]                       rem_r, rem_nxt;
  logic [dbrv_pkg::DIV_W-1:0]        quo_r, quo_nxt;
  logic [24:0]                       shifted;
  logic [24:0]                       diff;
  logic                              fits;

  // one shift-subtract step
  always_comb begin
    shifted  = {rem_r, quo_r[dbrv_pkg::DIV_W-1]};
    diff     = shifted - {1'b0, divisor};
    fits     = shifted >= {1'b0, divisor};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = dbrv_pkg::DIV_CNT_W'(dbrv_pkg::DIV_W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[23:0] : shifted[23:0];
      quo_nxt = {quo_r[dbrv_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/dbrv_dp.sv -----
// Datapath: row store memory, disparity arithmetic, hole filling, output register.
// Depends on dbrv_pkg and dbrv_div.
module dbrv_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dbrv_pkg::cfg_t       cfg,
  input  dbrv_pkg::cmd_t       cmd,
  output dbrv_pkg::sts_t       sts,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  logic [7:0]           in_depth_code,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_pixel_valid,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic                 out_row_done
);

  localparam int CW = dbrv_pkg::COL_W;
  localparam int AW = dbrv_pkg::ADDR_W;
  localparam int GW = dbrv_pkg::GEN_W;
  localparam int WW = dbrv_pkg::WORD_W;

  logic [WW-1:0]  mem [2**AW];
  logic [WW-1:0]  rd_r;
  logic [AW-1:0]  mem_addr;
  logic [WW-1:0]  mem_wdata;
  logic           mem_we;
  logic           mem_re;

  logic [23:0]    pix_in_r;
  logic [7:0]     code_r;
  logic [23:0]    cm_r;
  logic [33:0]    prod_r;
  logic [CW-1:0]  col_r;
  logic           bank_r;
  logic           prev_r;
  logic [GW-1:0]  gen_r [2];
  logic [23:0]    fill_r;
  logic [AW-1:0]  ptr_r;
  logic           res_pv_r;
  logic [23:0]    res_pix_r;
  logic           res_done_r;
  logic           out_valid_r;
  logic           out_pv_r;
  logic [23:0]    out_pix_r;
  logic           out_done_r;

  logic [10:0]    eff_w;
  logic [10:0]    emit_col;
  logic [23:0]    raw;
  logic [17:0]    luma;
  logic           hole;
  logic [23:0]    pix_sel;
  logic           black;
  logic           row_end;
  logic           div_busy;
  logic [dbrv_pkg::DIV_W-1:0] quo;
  logic [dbrv_pkg::DIV_W-1:0] dividend;
  logic [CW-1:0]  place_col;

  dbrv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (cm_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  // width saturated into 2..MAX_WIDTH, emitted column and row end
  always_comb begin
    if (cfg.width < 11'd2) eff_w = 11'd2;
    else if (cfg.width > 11'(dbrv_pkg::MAX_WIDTH)) eff_w = 11'(dbrv_pkg::MAX_WIDTH);
    else eff_w = cfg.width;
    emit_col = ({1'b0, col_r} < eff_w) ? (eff_w - 11'd1 - {1'b0, col_r}) : '0;
    row_end  = {1'b0, col_r} >= (eff_w - 11'd1);
  end

  // hole test and fill on the emitted pixel
  always_comb begin
    raw = (rd_r[WW-1] && (rd_r[WW-2:24] == gen_r[~bank_r])) ? rd_r[23:0] : '0;
    luma = dbrv_pkg::LUMA_R * 18'(raw[23:16]) + dbrv_pkg::LUMA_G * 18'(raw[15:8])
         + dbrv_pkg::LUMA_B * 18'(raw[7:0]);
    hole = luma < dbrv_pkg::LUMA_HOLE;
    if (emit_col != (eff_w - 11'd1) && emit_col != '0 && hole) pix_sel = fill_r;
    else pix_sel = raw;
  end

  // placement decision and target column
  always_comb begin
    black     = (cm_r == '0) || (prod_r <= {10'b0, cfg.numer});
    dividend  = 25'(cfg.numer) + 25'(cm_r) - 25'd1;
    place_col = black ? col_r : (col_r - quo[CW-1:0]);
  end

  // memory port selection
  always_comb begin
    mem_addr  = ptr_r;
    mem_wdata = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    unique case (cmd.mem_op)
      dbrv_pkg::MEM_NONE: ;
      dbrv_pkg::MEM_EMIT_RD: begin
        mem_addr = {~bank_r, emit_col[CW-1:0]};
        mem_re   = 1'b1;
      end
      dbrv_pkg::MEM_PLACE_WR: begin
        mem_addr  = {bank_r, place_col};
        mem_wdata = {1'b1, gen_r[bank_r], (black ? 24'd0 : pix_in_r)};
        mem_we    = 1'b1;
      end
      dbrv_pkg::MEM_SCRUB_RD: mem_re = 1'b1;
      dbrv_pkg::MEM_SCRUB_WR: mem_we = rd_r[WW-1] && (rd_r[WW-2:24] != gen_r[ptr_r[AW-1]]);
      dbrv_pkg::MEM_CLEAR_WR: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_r <= mem[mem_addr];
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      bank_r      <= 1'b0;
      prev_r      <= 1'b0;
      gen_r[0]    <= '0;
      gen_r[1]    <= '0;
      fill_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.mem_op == dbrv_pkg::MEM_SCRUB_WR || cmd.mem_op == dbrv_pkg::MEM_CLEAR_WR)
        ptr_r <= ptr_r + 1'b1;
      if (cmd.capture && prev_r) fill_r <= pix_sel;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (row_end) begin
          col_r          <= '0;
          bank_r         <= ~bank_r;
          prev_r         <= 1'b1;
          gen_r[~bank_r] <= gen_r[~bank_r] + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pix_in_r <= {in_red, in_green, in_blue};
      code_r   <= in_depth_code;
    end
    if (cmd.calc_cm) cm_r <= 24'(code_r) * 24'(cfg.depth_max);
    if (cmd.calc_prod) prod_r <= 34'(col_r) * 34'(cm_r);
    if (cmd.capture) begin
      res_pv_r   <= prev_r;
      res_pix_r  <= prev_r ? pix_sel : 24'd0;
      res_done_r <= prev_r && (emit_col == '0);
    end
    if (cmd.finish) begin
      out_pv_r   <= res_pv_r;
      out_pix_r  <= res_pix_r;
      out_done_r <= res_done_r;
    end
  end

  assign sts.place_black = black;
  assign sts.div_busy    = div_busy;
  assign sts.ptr_last    = &ptr_r;
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_pixel_valid = out_pv_r;
  assign out_red         = out_pix_r[23:16];
  assign out_green       = out_pix_r[15:8];
  assign out_blue        = out_pix_r[7:0];
  assign out_row_done    = out_done_r;

endmodule

// ----- rtl/dbrv_ctrl.sv -----
// Controller state machine sequencing one item through the datapath.
// Depends on dbrv_pkg.
module dbrv_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  dbrv_pkg::sts_t  sts,
  output dbrv_pkg::cmd_t  cmd
);

  dbrv_pkg::ctrl_state_t state_r, state_nxt;
  logic                  pass_r, pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dbrv_pkg::ST_CLEAR;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.mem_op = dbrv_pkg::MEM_NONE;
    unique case (state_r)
      dbrv_pkg::ST_CLEAR: begin
        cmd.mem_op = dbrv_pkg::MEM_CLEAR_WR;
        if (sts.ptr_last) state_nxt = dbrv_pkg::ST_IDLE;
      end
      dbrv_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) state_nxt = dbrv_pkg::ST_MUL;
      end
      dbrv_pkg::ST_MUL: begin
        cmd.calc_cm = 1'b1;
        cmd.mem_op  = dbrv_pkg::MEM_EMIT_RD;
        state_nxt   = dbrv_pkg::ST_PROD;
      end
      dbrv_pkg::ST_PROD: begin
        cmd.calc_prod = 1'b1;
        cmd.capture   = 1'b1;
        state_nxt     = dbrv_pkg::ST_DEC;
      end
      dbrv_pkg::ST_DEC: begin
        if (sts.place_black) begin
          state_nxt = dbrv_pkg::ST_WRITE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = dbrv_pkg::ST_DIV;
        end
      end
      dbrv_pkg::ST_DIV: begin
        if (!sts.div_busy) state_nxt = dbrv_pkg::ST_WRITE;
      end
      dbrv_pkg::ST_WRITE: begin
        cmd.mem_op = dbrv_pkg::MEM_PLACE_WR;
        pass_nxt   = 1'b0;
        state_nxt  = dbrv_pkg::ST_SRD;
      end
      dbrv_pkg::ST_SRD: begin
        cmd.mem_op = dbrv_pkg::MEM_SCRUB_RD;
        state_nxt  = dbrv_pkg::ST_SWR;
      end
      dbrv_pkg::ST_SWR: begin
        cmd.mem_op = dbrv_pkg::MEM_SCRUB_WR;
        pass_nxt   = 1'b1;
        state_nxt  = pass_r ? dbrv_pkg::ST_DONE : dbrv_pkg::ST_SRD;
      end
      dbrv_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = dbrv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dbrv_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/depth_based_right_view_warp.sv -----
// Depth-based right view warp: shifts left-view pixels by a depth-driven disparity
// into double-buffered rows and emits the previous row right to left with hole filling.
// Depends on dbrv_pkg, dbrv_ctrl, dbrv_dp.
//
// One result item per input item. An item is handled faster when its pixel is dropped
// or has unknown depth than when its disparity is computed; the 25-step radix-2
// divider and the wait to see it idle make the difference, and a new item is
// taken as soon as the previous one is handed to the output register. After reset
// all 2048 row store entries are swept, with no item taken; configuration writes
// are taken all the while. Row store entries carry a per-bank generation tag, so a
// bank is cleared at once at a row switch; two stale entries are scrubbed per item.
// The last row of a frame leaves the block only while a further row is fed in.
module depth_based_right_view_warp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_depth_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_pixel_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_row_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dbrv_pkg::cfg_t cfg_r;
  dbrv_pkg::cmd_t cmd;
  dbrv_pkg::sts_t sts;
  logic           wr_en;

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_max <= dbrv_pkg::DEPTH_MAX_RST;
      cfg_r.numer     <= dbrv_pkg::NUMER_RST;
      cfg_r.width     <= dbrv_pkg::WIDTH_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        dbrv_pkg::REG_DEPTH_MAX: cfg_r.depth_max <= pwdata[15:0];
        dbrv_pkg::REG_NUMER:     cfg_r.numer     <= pwdata[23:0];
        dbrv_pkg::REG_WIDTH:     cfg_r.width     <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      dbrv_pkg::REG_DEPTH_MAX: prdata = 32'(cfg_r.depth_max);
      dbrv_pkg::REG_NUMER:     prdata = 32'(cfg_r.numer);
      dbrv_pkg::REG_WIDTH:     prdata = 32'(cfg_r.width);
      default:                 prdata = '0;
    endcase
  end

  dbrv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dbrv_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .sts             (sts),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_depth_code   (in_depth_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_valid (out_pixel_valid),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_row_done    (out_row_done)
  );

`ifndef SYNTHESIS
  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  // row end only flagged while a row is emitted
  a_done_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_done |-> out_pixel_valid)
    else $error("row done without an emitted pixel");

  // no color before the first row completes
  a_black_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_valid |-> out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
    else $error("color output without an emitted pixel");

  // divider never runs while the block waits for an item
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.div_busy)
    else $error("divider busy while idle");
`endif

endmodule
